@@ hdl/spq_pkg.sv @@
package spq_pkg;

    localparam int DATA_W       = 32;
    localparam int COUNT_W      = 5;
    localparam int CAPACITY_DEF = 16;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic push;
        logic shift_down;
    } cell_ctrl_t;

endpackage

@@ hdl/spq_cell.sv @@
module spq_cell (
    input  logic                              clk,
    input  spq_pkg::cell_ctrl_t               ctrl,
    input  logic                              valid,
    input  logic signed [spq_pkg::DATA_W-1:0] value,
    input  logic signed [spq_pkg::DATA_W-1:0] left_entry,
    input  logic                              left_gt,
    input  logic signed [spq_pkg::DATA_W-1:0] right_entry,
    output logic signed [spq_pkg::DATA_W-1:0] entry,
    output logic                              gt
);
    import spq_pkg::*;

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;

    assign gt    = valid && (entry_reg > value);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.push && (gt || !valid))
        begin
            entry_next = left_gt ? left_entry : value;
        end
        else if (ctrl.shift_down)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

@@ hdl/sorted_priority_queue_core.sv @@
// The result strobe rises in the cycle after a request is accepted.
// No new request is accepted while busy; busy covers the result cycle.
// The cell chain registers the updated entries in the accept cycle; top is read after.
// Reset clears the entry count, pending and overflow flags, and sets the mode to largest first.
// Entries themselves are not reset. The receiver cannot stall results.
module sorted_priority_queue_core #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_data,
    input  logic                               start,
    output logic                               busy,
    input  logic                               op,
    input  logic signed [spq_pkg::DATA_W-1:0]  value,
    output logic                               done,
    output logic signed [spq_pkg::DATA_W-1:0]  top_value,
    output logic        [spq_pkg::COUNT_W-1:0] entry_count,
    output logic                               is_empty,
    output logic                               is_full,
    output logic                               overflow
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic          largest_first_reg;
    logic          pending_reg;
    logic          overflow_reg;
    logic          overflow_next;
    logic [CW-1:0] occ_reg;
    logic [CW-1:0] occ_next;
    logic [CW-1:0] occ_m1;
    logic          accept;
    logic          full;
    cell_ctrl_t    ctrl;

    logic signed [DATA_W-1:0] ent [CAPACITY];
    logic                     gts [CAPACITY];

    assign cfg_ready = 1'b1;
    assign busy      = pending_reg;
    assign accept    = start && !pending_reg;
    assign full      = (occ_reg == CW'(CAPACITY));

    assign ctrl.push       = accept && (op == OP_PUSH) && !full;
    assign ctrl.shift_down = accept && (op == OP_POP) && (occ_reg != '0) && !largest_first_reg;

    always_comb
    begin
        occ_next      = occ_reg;
        overflow_next = overflow_reg;
        if (accept)
        begin
            overflow_next = (op == OP_PUSH) && full;
            if (ctrl.push)
            begin
                occ_next = occ_reg + CW'(1);
            end
            else if ((op == OP_POP) && (occ_reg != '0))
            begin
                occ_next = occ_reg - CW'(1);
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic signed [DATA_W-1:0] left_e;
            logic signed [DATA_W-1:0] right_e;
            logic                     left_g;

            if (i == 0)
            begin : g_first
                assign left_e = '0;
                assign left_g = 1'b0;
            end
            else
            begin : g_mid
                assign left_e = ent[i-1];
                assign left_g = gts[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_e = ent[i];
            end
            else
            begin : g_inner
                assign right_e = ent[i+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .valid       (occ_reg > CW'(i)),
                .value       (value),
                .left_entry  (left_e),
                .left_gt     (left_g),
                .right_entry (right_e),
                .entry       (ent[i]),
                .gt          (gts[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            largest_first_reg <= 1'b1;
            pending_reg       <= 1'b0;
            overflow_reg      <= 1'b0;
            occ_reg           <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                largest_first_reg <= cfg_data;
            end
            pending_reg  <= accept;
            overflow_reg <= overflow_next;
            occ_reg      <= occ_next;
        end
    end

    assign occ_m1 = occ_reg - CW'(1);

    always_comb
    begin
        if (occ_reg == '0)
        begin
            top_value = '0;
        end
        else if (largest_first_reg)
        begin
            top_value = ent[occ_m1[IW-1:0]];
        end
        else
        begin
            top_value = ent[0];
        end
    end

    assign done        = pending_reg;
    assign entry_count = COUNT_W'(occ_reg);
    assign is_empty    = (occ_reg == '0);
    assign is_full     = full;
    assign overflow    = overflow_reg;

endmodule

@@ dv/sorted_priority_queue_core_tb.sv @@
`timescale 1ns / 1ps

module sorted_priority_queue_core_tb;

    localparam int DEPTH      = spq_pkg::CAPACITY_DEF;
    localparam int DW         = spq_pkg::DATA_W;
    localparam int CW         = spq_pkg::COUNT_W;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic          op;
        logic [DW-1:0] value;
    } request_t;

    typedef struct packed {
        logic [DW-1:0] top;
        logic [CW-1:0] count;
        logic          empty;
        logic          full;
        logic          ovf;
    } outcome_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_data;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 op = spq_pkg::OP_PUSH;
    logic signed [DW-1:0] value = '0;
    logic                 done;
    logic signed [DW-1:0] top_value;
    logic        [CW-1:0] entry_count;
    logic                 is_empty;
    logic                 is_full;
    logic                 overflow;

    request_t             pending_requests[$];
    outcome_t             awaited_outcomes[$];

    logic signed [DW-1:0] model_entries[DEPTH];
    int                   model_count;
    logic                 model_largest_first;

    int                   mismatches;
    int                   n_queued;
    int                   n_accepted;
    int                   n_cfg_writes;
    int                   stall_cycles;
    logic                 req_taken;
    bit                   sender_idles;
    logic signed [DW-1:0] last_pushed;

    sorted_priority_queue_core #(
        .CAPACITY(DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .start(start),
        .busy(busy),
        .op(op),
        .value(value),
        .done(done),
        .top_value(top_value),
        .entry_count(entry_count),
        .is_empty(is_empty),
        .is_full(is_full),
        .overflow(overflow)
    );

    always #1 clk = ~clk;

    task automatic note_mismatch(input string msg);
        mismatches++;
        $display("mismatch: %s", msg);
    endtask

    task automatic predict_request(input logic o, input logic signed [DW-1:0] v);
        outcome_t res;
        int       pos;
        res = '0;
        if (o == spq_pkg::OP_PUSH)
        begin
            if (model_count >= DEPTH)
            begin
                res.ovf = 1'b1;
            end
            else
            begin
                pos = model_count;
                while (pos > 0 && model_entries[pos-1] > v)
                begin
                    model_entries[pos] = model_entries[pos-1];
                    pos--;
                end
                model_entries[pos] = v;
                model_count++;
            end
        end
        else if (model_count > 0)
        begin
            if (!model_largest_first)
            begin
                for (int i = 0; i + 1 < model_count; i++)
                begin
                    model_entries[i] = model_entries[i+1];
                end
            end
            model_count--;
        end
        if (model_count > 0)
        begin
            res.top = model_largest_first ? model_entries[model_count-1] : model_entries[0];
        end
        res.count = model_count[CW-1:0];
        res.empty = (model_count == 0);
        res.full  = (model_count >= DEPTH);
        awaited_outcomes.insert(awaited_outcomes.size(), res);
    endtask

    // sample results, then advance the model
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_outcomes.size() == 0)
                begin
                    note_mismatch($sformatf("result with none pending, top %0d count %0d",
                                            top_value, entry_count));
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (top_value !== $signed(want.top))
                        note_mismatch($sformatf("top_value %0d, want %0d",
                                                top_value, $signed(want.top)));
                    if (entry_count !== want.count)
                        note_mismatch($sformatf("entry_count %0d, want %0d",
                                                entry_count, want.count));
                    if (is_empty !== want.empty)
                        note_mismatch($sformatf("is_empty %b, want %b", is_empty, want.empty));
                    if (is_full !== want.full)
                        note_mismatch($sformatf("is_full %b, want %b", is_full, want.full));
                    if (overflow !== want.ovf)
                        note_mismatch($sformatf("overflow %b, want %b", overflow, want.ovf));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                model_largest_first = cfg_data;
                n_cfg_writes++;
            end
            if (start && !busy)
            begin
                predict_request(op, value);
                n_accepted++;
            end
        end
        req_taken <= rst_n && start && !busy;
    end

    // drive requests from the pending queue
    always @(negedge clk)
    begin
        logic     next_start;
        request_t r;
        next_start = start;
        if (!rst_n)
        begin
            next_start = 1'b0;
        end
        else if (!start || req_taken)
        begin
            next_start = 1'b0;
            if (pending_requests.size() > 0 &&
                !(sender_idles && $urandom_range(0, 99) < 26))
            begin
                r = pending_requests.pop_front();
                op    <= r.op;
                value <= r.value;
                next_start = 1'b1;
            end
        end
        start <= next_start;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
            begin
                stall_cycles <= 0;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    task automatic queue_request(input logic o, input logic signed [DW-1:0] v);
        request_t r;
        r.op    = o;
        r.value = v;
        pending_requests.insert(pending_requests.size(), r);
        n_queued++;
        if (o == spq_pkg::OP_PUSH) last_pushed = v;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (n_accepted != n_queued || awaited_outcomes.size() != 0 || start)
        begin
            @(negedge clk);
        end
        repeat (3) @(negedge clk);
    endtask

    task automatic write_mode(input logic m);
        int c0;
        wait_drained();
        c0 = n_cfg_writes;
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(negedge clk);
        while (n_cfg_writes == c0) @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_data  <= $urandom_range(0, 1);
    endtask

    function automatic logic signed [DW-1:0] pick_value();
        logic signed [DW-1:0] v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 6))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7FFF_FFFF;
                    2: v = 32'sh8000_0001;
                    3: v = 32'sh7FFF_FFFE;
                    4: v = -1;
                    5: v = 1;
                    default: v = 0;
                endcase
            end
            1, 2, 3: v = $signed($urandom_range(0, 16)) - 8;
            4: v = last_pushed;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic random_phase(input int n);
        int   made;
        int   burst;
        int   push_pct;
        logic o;
        made = 0;
        while (made < n)
        begin
            burst = $urandom_range(4, 40);
            case ($urandom_range(0, 2))
                0: push_pct = 85;
                1: push_pct = 15;
                default: push_pct = 50;
            endcase
            for (int i = 0; i < burst && made < n; i++)
            begin
                o = ($urandom_range(0, 99) < push_pct) ? spq_pkg::OP_PUSH : spq_pkg::OP_POP;
                queue_request(o, o == spq_pkg::OP_PUSH ? pick_value() : $signed($urandom));
                made++;
            end
        end
    endtask

    initial
    begin
        logic phase_modes[8];
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = 1'b0;
        req_taken    = 1'b0;
        mismatches   = 0;
        n_queued     = 0;
        n_accepted   = 0;
        n_cfg_writes = 0;
        stall_cycles = 0;
        sender_idles = 1'b1;
        last_pushed  = 0;
        model_count  = 0;
        model_largest_first = 1'b1;
        phase_modes = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        queue_request(spq_pkg::OP_POP, 32'sh1234_5678);
        queue_request(spq_pkg::OP_PUSH, 32'sh7FFF_FFFF);
        queue_request(spq_pkg::OP_PUSH, 32'sh8000_0000);
        queue_request(spq_pkg::OP_PUSH, 0);
        queue_request(spq_pkg::OP_PUSH, -1);
        queue_request(spq_pkg::OP_PUSH, 0);
        queue_request(spq_pkg::OP_PUSH, 32'sh7FFF_FFFF);
        for (int i = 0; i < 10; i++)
        begin
            queue_request(spq_pkg::OP_PUSH, i * 3 - 15);
        end
        queue_request(spq_pkg::OP_PUSH, 5);
        queue_request(spq_pkg::OP_POP, -1);

        // flip direction with entries held
        write_mode(1'b0);
        queue_request(spq_pkg::OP_POP, 32'sh5555_AAAA);
        queue_request(spq_pkg::OP_POP, 0);
        queue_request(spq_pkg::OP_PUSH, 32'sh8000_0000);
        queue_request(spq_pkg::OP_PUSH, 1);

        for (int p = 0; p < 8; p++)
        begin
            write_mode(phase_modes[p]);
            sender_idles = (p != 3);
            random_phase(210);
        end

        wait_drained();
        repeat (4) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
